// ===== hw/rtl/multi_context_byte_fifo_top_assert.svh =====
// Assertion macros for the multi-context byte FIFO.
`ifndef MULTI_CONTEXT_BYTE_FIFO_TOP_ASSERT_SVH
`define MULTI_CONTEXT_BYTE_FIFO_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on each rising edge; skip while reset is high.
`define MCBF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Check a property on each rising edge, reset included.
`define MCBF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`else

`define MCBF_ASSERT(label, clk, rst, prop)
`define MCBF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== hw/rtl/mcbf_pkg.sv =====
// Types and constants shared by the multi-context byte FIFO.
package mcbf_pkg;

  localparam int unsigned CFG_AW    = 2;
  localparam int unsigned CFG_DW    = 8;
  localparam int unsigned NUM_DREGS = 4;
  localparam logic [CFG_DW-1:0] DEPTH_RESET = 8'd16;

  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_GET    = 2'd1,
    ACT_SELECT = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data_in;
    logic [1:0] context_sel;
  } req_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       put_accepted;
    logic       get_had_data;
    logic       unread_after;
    logic       space_after;
    logic [1:0] active_ctx;
  } rsp_item_t;

endpackage

// ===== hw/rtl/multi_context_byte_fifo_top.sv =====
// Multi-context byte ring FIFO: top level.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries one action per
//   transaction: put a byte, get a byte, select a context, or clear and
//   select a context. Response channel (rsp_valid / rsp_stall / rsp) returns
//   exactly one result transaction per request, in order.
//   Results are registered and show in the cycle after a request is taken.
//   Throughput is one transaction per cycle while req_stall is low; the byte
//   store has one write port and one registered read port, and the per-context
//   pointers sit in flops, so a get right after a put to the same slot sees
//   the byte. Depth registers are written through cfg_we / cfg_addr /
//   cfg_wdata; the user must do so only while the block is idle, and the
//   block does not enforce it. A depth below 2 acts as 2, above REGION_BYTES
//   as REGION_BYTES. Reset zeroes pointers, selects context zero, loads every
//   depth with 16, and starts a clearing pass that writes zero to every byte
//   of storage (NUM_CONTEXTS * REGION_BYTES bytes, 1024 by default) while
//   req_stall stays high. Configuration writes are taken during the pass.
//   When the receiver stalls, the held result stays unchanged and req_stall
//   rises in the same cycle, so no new request enters until it drains.
module multi_context_byte_fifo_top
  import mcbf_pkg::*;
#(
  parameter int unsigned NUM_CONTEXTS = 4,
  parameter int unsigned REGION_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_item_t         req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_item_t         rsp,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

`include "multi_context_byte_fifo_top_assert.svh"

  localparam int unsigned CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int unsigned PW        = $clog2(REGION_BYTES);
  localparam int unsigned DW        = $clog2(REGION_BYTES + 1);
  localparam int unsigned MEM_DEPTH = NUM_CONTEXTS * REGION_BYTES;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  // Configuration and architectural state.
  logic [CFG_DW-1:0] depth_reg [NUM_DREGS];
  logic [PW-1:0]     read_ptr  [NUM_CONTEXTS];
  logic [PW-1:0]     write_ptr [NUM_CONTEXTS];
  logic [1:0]        current_ctx;

  // Storage and clearing pass.
  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        mem_q;
  logic              clearing;
  logic [MEM_AW-1:0] clr_cnt;

  // Result register.
  logic       rsp_is_get;
  logic       rsp_put_ok;
  logic       rsp_get_ok;
  logic       rsp_unread;
  logic       rsp_space;
  logic [1:0] rsp_ctx;

  logic req_accept;

  // Step logic.
  logic             sel_ok;
  logic [1:0]       ctx_next;
  logic [CTX_W-1:0] ctx_idx;
  logic [8:0]       d_raw;
  logic [DW-1:0]    d;
  logic [PW-1:0]    rp_raw, wp_raw, rp, wp;
  logic [DW-1:0]    rp_inc, wp_inc, wp_fin_inc;
  logic [PW-1:0]    rp_nxt, wp_nxt, wp_fin_nxt;
  logic [PW-1:0]    rp_fin, wp_fin, prev_ptr, rd_ptr;
  logic             put_ok, get_ok;
  logic [MEM_AW-1:0] base, rd_addr, wr_addr;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  // Hold off requests during the clearing pass or while a result waits.
  assign req_stall  = clearing | (rsp_valid & rsp_stall);
  assign req_accept = req_valid & ~req_stall;

  always_comb begin
    sel_ok   = ((req.action == ACT_SELECT) || (req.action == ACT_CLEAR)) &&
               (int'(req.context_sel) < NUM_CONTEXTS);
    ctx_next = sel_ok ? req.context_sel : current_ctx;
    ctx_idx  = CTX_W'(ctx_next);

    // Clamp depth into [2, REGION_BYTES].
    d_raw = {1'b0, depth_reg[ctx_next]};
    if (d_raw < 9'd2) begin
      d_raw = 9'd2;
    end else if (d_raw > 9'(REGION_BYTES)) begin
      d_raw = 9'(REGION_BYTES);
    end
    d = DW'(d_raw);

    // A clear zeroes the named context's pointers before the step uses them.
    if (sel_ok && (req.action == ACT_CLEAR)) begin
      rp_raw = '0;
      wp_raw = '0;
    end else begin
      rp_raw = read_ptr[ctx_idx];
      wp_raw = write_ptr[ctx_idx];
    end

    // Stale pointers read as zero.
    rp = (DW'(rp_raw) >= d) ? '0 : rp_raw;
    wp = (DW'(wp_raw) >= d) ? '0 : wp_raw;

    rp_inc = DW'(rp) + 1'b1;
    wp_inc = DW'(wp) + 1'b1;
    rp_nxt = (rp_inc >= d) ? '0 : PW'(rp_inc);
    wp_nxt = (wp_inc >= d) ? '0 : PW'(wp_inc);

    put_ok = (req.action == ACT_PUT) && (wp_nxt != rp);
    get_ok = (req.action == ACT_GET) && (rp != wp);

    wp_fin = put_ok ? wp_nxt : wp;
    rp_fin = get_ok ? rp_nxt : rp;

    wp_fin_inc = DW'(wp_fin) + 1'b1;
    wp_fin_nxt = (wp_fin_inc >= d) ? '0 : PW'(wp_fin_inc);

    // Empty get returns the slot just behind the read pointer.
    prev_ptr = (rp == '0) ? PW'(d - 1'b1) : PW'(rp - 1'b1);
    rd_ptr   = get_ok ? rp : prev_ptr;

    base    = MEM_AW'(ctx_idx) * MEM_AW'(REGION_BYTES);
    rd_addr = base + MEM_AW'(rd_ptr);
    wr_addr = base + MEM_AW'(wp);

    // The clearing pass owns the write port until it finishes.
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = req_accept & put_ok;
      mem_waddr = wr_addr;
      mem_wdata = req.data_in;
    end
  end

  // Byte store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == MEM_AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Depth registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DREGS; i++) begin
        depth_reg[i] <= DEPTH_RESET;
      end
    end else if (cfg_we) begin
      depth_reg[cfg_addr] <= cfg_wdata;
    end
  end

  // Pointers and active context: advance on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CONTEXTS; i++) begin
        read_ptr[i]  <= '0;
        write_ptr[i] <= '0;
      end
      current_ctx <= '0;
    end else if (req_accept) begin
      read_ptr[ctx_idx]  <= rp_fin;
      write_ptr[ctx_idx] <= wp_fin;
      current_ctx        <= ctx_next;
    end
  end

  // Result register: load on accept, drop once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      rsp_is_get <= (req.action == ACT_GET);
      rsp_put_ok <= put_ok;
      rsp_get_ok <= get_ok;
      rsp_unread <= (rp_fin != wp_fin);
      rsp_space  <= (wp_fin_nxt != rp_fin);
      rsp_ctx    <= ctx_next;
    end
  end

  // Only a get returns a byte; every other action reports zero.
  assign rsp.data_out     = rsp_is_get ? mem_q : 8'd0;
  assign rsp.put_accepted = rsp_put_ok;
  assign rsp.get_had_data = rsp_get_ok;
  assign rsp.unread_after = rsp_unread;
  assign rsp.space_after  = rsp_space;
  assign rsp.active_ctx   = rsp_ctx;

  // A stored byte always leaves the ring non-empty.
  `MCBF_ASSERT(a_put_leaves_data, clk, rst, rsp_valid && rsp_put_ok |-> rsp_unread)
  // A byte taken out always leaves room for a put.
  `MCBF_ASSERT(a_get_leaves_space, clk, rst, rsp_valid && rsp_get_ok |-> rsp_space)
  // Every accepted request yields a result on the next cycle.
  `MCBF_ASSERT(a_accept_to_result, clk, rst, req_accept |=> rsp_valid)
  // No request slips in while storage is still being cleared.
  `MCBF_ASSERT_ALWAYS(a_no_accept_clearing, clk, clearing |-> !req_accept)

endmodule
